FILE: rtl/aavr_pkg.sv
`default_nettype none
package aavr_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int KQ           = 30;
  localparam int CORDIC_STEPS = 30;
  localparam int SQRT_STEPS   = 32;
  localparam int DIV_STEPS    = KQ + 1;

  localparam logic [63:0]        HALF_PI_Q30 = 64'd1686629713;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [63:0] TURN    = 64'd360 << FRAC_BITS;
  localparam logic [63:0] QUARTER = 64'd90 << FRAC_BITS;
  localparam int TURN_LOG = $clog2(TURN);
  localparam int ANG_W    = ((TURN_LOG > 33) ? TURN_LOG : 33) + 1;
  localparam int ANG_NQ   = (33 > TURN_LOG) ? 33 - TURN_LOG : 1;
  localparam int ANG_PER  = 8;
  localparam int ANG_MS   = (ANG_NQ + ANG_PER - 1) / ANG_PER;
  localparam logic [63:0] ANG_OFS = TURN - ((64'd1 << 31) % TURN);

  localparam int LAX     = 5 + SQRT_STEPS + 1 + DIV_STEPS + 1;
  localparam int LANG    = 1 + ANG_MS + 2 + KQ + 2 + CORDIC_STEPS + 1;
  localparam int ANG_PAD = LAX - LANG;
  localparam int LCOMB   = 7;
  localparam int LAT     = LAX + LCOMB;

  typedef enum logic [1:0] {
    QUAD_0,
    QUAD_90,
    QUAD_180,
    QUAD_270
  } quad_t;

  typedef struct packed {
    logic [2:0][31:0] v;
    logic [2:0]       neg;
    logic             zero;
  } side_t;

  function automatic logic signed [33:0] atan_q30(input int i);
    case (i)
      0:       return 34'sh03243F6A8;
      1:       return 34'sh01DAC6705;
      2:       return 34'sh00FADBAFC;
      3:       return 34'sh007F56EA6;
      4:       return 34'sh003FEAB76;
      5:       return 34'sh001FFD55B;
      6:       return 34'sh000FFFAAA;
      7:       return 34'sh0007FFF55;
      8:       return 34'sh0003FFFEA;
      9:       return 34'sh0001FFFFD;
      10:      return 34'sh0000FFFFF;
      11:      return 34'sh00007FFFF;
      12:      return 34'sh00003FFFF;
      13:      return 34'sh00001FFFF;
      14:      return 34'sh00000FFFF;
      15:      return 34'sh000007FFF;
      16:      return 34'sh000003FFF;
      17:      return 34'sh000001FFF;
      18:      return 34'sh000000FFF;
      19:      return 34'sh0000007FF;
      20:      return 34'sh0000003FF;
      21:      return 34'sh0000001FF;
      22:      return 34'sh0000000FF;
      23:      return 34'sh00000007F;
      24:      return 34'sh00000003F;
      25:      return 34'sh00000001F;
      26:      return 34'sh00000000F;
      27:      return 34'sh000000008;
      28:      return 34'sh000000004;
      29:      return 34'sh000000002;
      default: return 34'sh000000000;
    endcase
  endfunction

endpackage
`default_nettype wire

FILE: rtl/axis_angle_vector_rotator.sv
// Throughput: one request per cycle when the result side is not stalled; set by
// the stage-per-step square root, axis divide, angle divide and CORDIC chains
// running side by side. A stall on the result side freezes every stage at once.
// Reset (synchronous, rst_n low) clears the stage valid bits only.
`default_nettype none
module axis_angle_vector_rotator import aavr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_vec_x,
  input  logic signed [31:0] in_vec_y,
  input  logic signed [31:0] in_vec_z,
  input  logic signed [31:0] in_axis_x,
  input  logic signed [31:0] in_axis_y,
  input  logic signed [31:0] in_axis_z,
  input  logic signed [31:0] in_angle_deg,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic               out_zero_axis,
  output logic               out_saturated
);

  function automatic logic [4:0] norm_shift(input logic [31:0] m);
    logic [4:0] hp;
    hp = '0;
    for (int p = 0; p < 32; p++) begin
      if (m[p]) hp = 5'(p);
    end
    return (hp >= 5'd30) ? 5'd0 : 5'd30 - hp;
  endfunction

  function automatic logic signed [79:0] mul40(input logic signed [39:0] a,
                                              input logic signed [39:0] b);
    return a * b;
  endfunction

  function automatic logic signed [39:0] rnd_q(input logic signed [79:0] x);
    logic signed [79:0] t;
    t = x + (80'sd1 <<< (KQ - 1));
    return t[KQ+39:KQ];
  endfunction

  logic           en;
  logic [LAT:1]   vld_r;

  assign en        = ~vld_r[LAT] | out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-1:1], in_valid};
    end
  end

  // stage 1: magnitudes, largest magnitude, angle offset
  logic [2:0][31:0] ain, vin, mag_nxt;
  logic [31:0]      m_nxt;
  side_t            side_nxt;
  side_t            side_r [1:LAT-1];
  logic [2:0][31:0] mag1_r;
  logic [31:0]      m1_r;
  logic [ANG_W-1:0] amod_r [0:ANG_MS];

  assign ain = {in_axis_z, in_axis_y, in_axis_x};
  assign vin = {in_vec_z, in_vec_y, in_vec_x};

  always_comb begin
    m_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      mag_nxt[i] = ain[i][31] ? 32'd0 - ain[i] : ain[i];
      if (mag_nxt[i] > m_nxt) m_nxt = mag_nxt[i];
      side_nxt.neg[i] = ain[i][31];
    end
    side_nxt.v    = vin;
    side_nxt.zero = (m_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[1] <= side_nxt;
      mag1_r    <= mag_nxt;
      m1_r      <= m_nxt;
      amod_r[0] <= ANG_W'({~in_angle_deg[31], in_angle_deg[30:0]});
    end
  end

  for (genvar g = 2; g < LAT; g++) begin : g_side
    always_ff @(posedge clk) begin
      if (en) side_r[g] <= side_r[g-1];
    end
  end

  // stages 2 to 5: common shift, squares, sum
  logic [4:0]       n2_r;
  logic [2:0][31:0] mag2_r, mag3_r, mag4_r;
  logic [2:0][63:0] sq4_r;
  logic [63:0]      sqn_r [0:SQRT_STEPS];
  logic [63:0]      sqq_r [0:SQRT_STEPS];
  logic [2:0][31:0] smag_r [0:SQRT_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      n2_r   <= norm_shift(m1_r);
      mag2_r <= mag1_r;
      for (int i = 0; i < 3; i++) begin
        mag3_r[i] <= mag2_r[i] << n2_r;
        sq4_r[i]  <= 64'(mag3_r[i]) * 64'(mag3_r[i]);
      end
      mag4_r    <= mag3_r;
      sqn_r[0]  <= sq4_r[0] + sq4_r[1] + sq4_r[2];
      sqq_r[0]  <= '0;
      smag_r[0] <= mag4_r;
    end
  end

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
    logic [63:0] trial;
    logic        ge;
    assign trial = sqq_r[j] + BIT;
    assign ge    = (sqn_r[j] >= trial);
    always_ff @(posedge clk) begin
      if (en) begin
        sqn_r[j+1]  <= ge ? sqn_r[j] - trial : sqn_r[j];
        sqq_r[j+1]  <= ge ? (sqq_r[j] >> 1) + BIT : sqq_r[j] >> 1;
        smag_r[j+1] <= smag_r[j];
      end
    end
  end

  // axis divide: k = (mag * 2^KQ + len/2) / len
  logic [2:0][31:0]          drem_r [0:DIV_STEPS];
  logic [2:0][DIV_STEPS-1:0] dlow_r [0:DIV_STEPS];
  logic [31:0]               dlen_r [0:DIV_STEPS];
  logic [31:0]               len_w;

  assign len_w = sqq_r[SQRT_STEPS][31:0];

  always_ff @(posedge clk) begin
    if (en) begin
      dlen_r[0] <= len_w;
      for (int i = 0; i < 3; i++) begin
        drem_r[0][i] <= 32'(({smag_r[SQRT_STEPS][i], KQ'(0)} + (32+KQ)'(len_w >> 1))
                        >> DIV_STEPS);
        dlow_r[0][i] <= DIV_STEPS'({smag_r[SQRT_STEPS][i], KQ'(0)}
                        + (32+KQ)'(len_w >> 1));
      end
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic [2:0][31:0]          drem_nxt;
    logic [2:0][DIV_STEPS-1:0] dlow_nxt;
    always_comb begin
      logic [32:0] rem2;
      for (int i = 0; i < 3; i++) begin
        rem2 = {drem_r[j][i], dlow_r[j][i][DIV_STEPS-1]};
        if (rem2 >= {1'b0, dlen_r[j]}) begin
          drem_nxt[i] = 32'(rem2 - {1'b0, dlen_r[j]});
          dlow_nxt[i] = {dlow_r[j][i][DIV_STEPS-2:0], 1'b1};
        end else begin
          drem_nxt[i] = rem2[31:0];
          dlow_nxt[i] = {dlow_r[j][i][DIV_STEPS-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        drem_r[j+1] <= drem_nxt;
        dlow_r[j+1] <= dlow_nxt;
        dlen_r[j+1] <= dlen_r[j];
      end
    end
  end

  logic signed [31:0] k_r [0:2];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        k_r[i] <= side_r[LAX-1].neg[i] ? 32'sd0 - 32'(dlow_r[DIV_STEPS][i])
                                       : 32'(dlow_r[DIV_STEPS][i]);
      end
    end
  end

  // angle: reduce modulo one turn
  for (genvar s = 0; s < ANG_MS; s++) begin : g_amod
    logic [ANG_W-1:0] amod_nxt;
    always_comb begin
      int idx;
      amod_nxt = amod_r[s];
      for (int t = 0; t < ANG_PER; t++) begin
        idx = ANG_NQ - 1 - (s * ANG_PER + t);
        if (idx >= 0) begin
          if (amod_nxt >= (ANG_W'(TURN) << idx)) begin
            amod_nxt = amod_nxt - (ANG_W'(TURN) << idx);
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) amod_r[s+1] <= amod_nxt;
    end
  end

  logic [ANG_W-1:0] ar_nxt, ar1_r, ah_nxt, rr_nxt;
  quad_t            q_nxt;
  logic [ANG_W-1:0] fr_r [0:KQ];
  logic [KQ-1:0]    ff_r [0:KQ];
  quad_t            fq_r [0:KQ];

  always_comb begin
    ar_nxt = amod_r[ANG_MS] + ANG_W'(ANG_OFS);
    if (ar_nxt >= ANG_W'(TURN)) ar_nxt = ar_nxt - ANG_W'(TURN);
    ah_nxt = (ar1_r >= ANG_W'(QUARTER << 1)) ? ar1_r - ANG_W'(QUARTER << 1) : ar1_r;
    rr_nxt = (ah_nxt >= ANG_W'(QUARTER)) ? ah_nxt - ANG_W'(QUARTER) : ah_nxt;
    q_nxt  = quad_t'({ar1_r >= ANG_W'(QUARTER << 1), ah_nxt >= ANG_W'(QUARTER)});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ar1_r   <= ar_nxt;
      fr_r[0] <= rr_nxt;
      ff_r[0] <= '0;
      fq_r[0] <= q_nxt;
    end
  end

  for (genvar j = 0; j < KQ; j++) begin : g_frac
    logic [ANG_W-1:0] r2;
    logic             ge;
    assign r2 = fr_r[j] << 1;
    assign ge = (r2 >= ANG_W'(QUARTER));
    always_ff @(posedge clk) begin
      if (en) begin
        fr_r[j+1] <= ge ? r2 - ANG_W'(QUARTER) : r2;
        ff_r[j+1] <= {ff_r[j][KQ-2:0], ge};
        fq_r[j+1] <= fq_r[j];
      end
    end
  end

  // radians, then CORDIC
  logic [63:0]        tm_r, tsum;
  quad_t              tq_r;
  logic signed [33:0] cx_r [0:CORDIC_STEPS];
  logic signed [33:0] cy_r [0:CORDIC_STEPS];
  logic signed [33:0] cz_r [0:CORDIC_STEPS];
  quad_t              cq_r [0:CORDIC_STEPS];

  assign tsum = tm_r + (64'd1 << (KQ - 1));

  always_ff @(posedge clk) begin
    if (en) begin
      tm_r    <= 64'(ff_r[KQ]) * HALF_PI_Q30;
      tq_r    <= fq_r[KQ];
      cx_r[0] <= CORDIC_GAIN;
      cy_r[0] <= '0;
      cz_r[0] <= $signed(tsum[KQ+33:KQ]);
      cq_r[0] <= tq_r;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    localparam logic signed [33:0] AT = atan_q30(i);
    logic signed [33:0] xs, ys;
    assign xs = cx_r[i] >>> i;
    assign ys = cy_r[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        if (!cz_r[i][33]) begin
          cx_r[i+1] <= cx_r[i] - ys;
          cy_r[i+1] <= cy_r[i] + xs;
          cz_r[i+1] <= cz_r[i] - AT;
        end else begin
          cx_r[i+1] <= cx_r[i] + ys;
          cy_r[i+1] <= cy_r[i] - xs;
          cz_r[i+1] <= cz_r[i] + AT;
        end
        cq_r[i+1] <= cq_r[i];
      end
    end
  end

  logic signed [33:0] pc_r [0:ANG_PAD];
  logic signed [33:0] ps_r [0:ANG_PAD];
  logic signed [33:0] cc_nxt, sc_nxt, fx, fy;

  assign fx = cx_r[CORDIC_STEPS];
  assign fy = cy_r[CORDIC_STEPS];

  always_comb begin
    case (cq_r[CORDIC_STEPS])
      QUAD_0:   begin cc_nxt = fx;         sc_nxt = fy;         end
      QUAD_90:  begin cc_nxt = 34'sd0 - fy; sc_nxt = fx;        end
      QUAD_180: begin cc_nxt = 34'sd0 - fx; sc_nxt = 34'sd0 - fy; end
      default:  begin cc_nxt = fy;         sc_nxt = 34'sd0 - fx; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pc_r[0] <= cc_nxt;
      ps_r[0] <= sc_nxt;
    end
  end

  for (genvar g = 1; g <= ANG_PAD; g++) begin : g_pad
    always_ff @(posedge clk) begin
      if (en) begin
        pc_r[g] <= pc_r[g-1];
        ps_r[g] <= ps_r[g-1];
      end
    end
  end

  // Rodrigues combine
  logic signed [39:0] kk [0:2];
  logic signed [39:0] vv [0:2];
  logic signed [39:0] cw;
  logic signed [79:0] pd1_r [0:2];
  logic signed [79:0] px1_r [0:5];
  logic signed [79:0] pvc1_r [0:2];
  logic signed [39:0] k1_r [0:2];
  logic signed [39:0] omc1_r, s1_r;
  logic signed [39:0] kv2_r, omc2_r, s2_r;
  logic signed [39:0] cr2_r [0:2];
  logic signed [39:0] vc2_r [0:2];
  logic signed [39:0] k2_r [0:2];
  logic signed [79:0] pk3_r [0:2];
  logic signed [79:0] pcs3_r [0:2];
  logic signed [39:0] vc3_r [0:2];
  logic signed [39:0] omc3_r, omc4_r;
  logic signed [39:0] t4_r [0:2];
  logic signed [39:0] crs4_r [0:2];
  logic signed [39:0] vc4_r [0:2];
  logic signed [79:0] pt5_r [0:2];
  logic signed [39:0] crs5_r [0:2];
  logic signed [39:0] vc5_r [0:2];
  logic signed [39:0] t6_r [0:2];
  logic signed [39:0] crs6_r [0:2];
  logic signed [39:0] vc6_r [0:2];
  logic signed [39:0] o_nxt [0:2];
  logic signed [31:0] ox_r [0:2];
  logic               zero_r, sat_r;
  logic               sat_nxt;
  logic signed [31:0] sel_nxt [0:2];

  always_comb begin
    cw = 40'(pc_r[ANG_PAD]);
    for (int i = 0; i < 3; i++) begin
      kk[i] = 40'(k_r[i]);
      vv[i] = 40'($signed(side_r[LAX].v[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pd1_r[i]  <= mul40(kk[i], vv[i]);
        pvc1_r[i] <= mul40(vv[i], cw);
        k1_r[i]   <= kk[i];
      end
      px1_r[0] <= mul40(kk[1], vv[2]);
      px1_r[1] <= mul40(kk[2], vv[1]);
      px1_r[2] <= mul40(kk[2], vv[0]);
      px1_r[3] <= mul40(kk[0], vv[2]);
      px1_r[4] <= mul40(kk[0], vv[1]);
      px1_r[5] <= mul40(kk[1], vv[0]);
      omc1_r   <= (40'sd1 <<< KQ) - cw;
      s1_r     <= 40'(ps_r[ANG_PAD]);

      kv2_r    <= rnd_q(pd1_r[0] + pd1_r[1] + pd1_r[2]);
      cr2_r[0] <= rnd_q(px1_r[0] - px1_r[1]);
      cr2_r[1] <= rnd_q(px1_r[2] - px1_r[3]);
      cr2_r[2] <= rnd_q(px1_r[4] - px1_r[5]);
      omc2_r   <= omc1_r;
      s2_r     <= s1_r;
      omc3_r   <= omc2_r;
      omc4_r   <= omc3_r;
      for (int i = 0; i < 3; i++) begin
        vc2_r[i]  <= rnd_q(pvc1_r[i]);
        k2_r[i]   <= k1_r[i];
        pk3_r[i]  <= mul40(k2_r[i], kv2_r);
        pcs3_r[i] <= mul40(cr2_r[i], s2_r);
        vc3_r[i]  <= vc2_r[i];
        t4_r[i]   <= rnd_q(pk3_r[i]);
        crs4_r[i] <= rnd_q(pcs3_r[i]);
        vc4_r[i]  <= vc3_r[i];
        pt5_r[i]  <= mul40(t4_r[i], omc4_r);
        crs5_r[i] <= crs4_r[i];
        vc5_r[i]  <= vc4_r[i];
        t6_r[i]   <= rnd_q(pt5_r[i]);
        crs6_r[i] <= crs5_r[i];
        vc6_r[i]  <= vc5_r[i];
      end
    end
  end

  always_comb begin
    sat_nxt = 1'b0;
    for (int i = 0; i < 3; i++) begin
      o_nxt[i] = vc6_r[i] + crs6_r[i] + t6_r[i];
      if (o_nxt[i] > 40'sd2147483647) begin
        sel_nxt[i] = 32'sh7FFFFFFF;
        sat_nxt    = 1'b1;
      end else if (o_nxt[i] < -40'sd2147483648) begin
        sel_nxt[i] = 32'sh80000000;
        sat_nxt    = 1'b1;
      end else begin
        sel_nxt[i] = o_nxt[i][31:0];
      end
      if (side_r[LAT-1].zero) sel_nxt[i] = $signed(side_r[LAT-1].v[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ox_r[i] <= sel_nxt[i];
      end
      zero_r <= side_r[LAT-1].zero;
      sat_r  <= sat_nxt & ~side_r[LAT-1].zero;
    end
  end

  assign out_x         = ox_r[0];
  assign out_y         = ox_r[1];
  assign out_z         = ox_r[2];
  assign out_zero_axis = zero_r;
  assign out_saturated = sat_r;

endmodule
`default_nettype wire

FILE: rtl/aavr_checker.sv
`default_nettype none
module aavr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_x,
  input logic [31:0] out_y,
  input logic [31:0] out_z,
  input logic        out_zero_axis,
  input logic        out_saturated
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown straight after reset");

  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("request side not tied to result stall");

  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_axis |-> !out_saturated)
    else $error("saturation flagged on zero axis");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
      && $stable(out_z) && $stable(out_zero_axis) && $stable(out_saturated))
    else $error("stalled result changed");

endmodule

bind axis_angle_vector_rotator aavr_checker u_aavr_checker (.*);
`default_nettype wire
